[design/ttch_pkg.sv]
package ttch_pkg;

    localparam int KIND_W        = 2;
    localparam int KEY_W         = 31;
    localparam int SLOT_OUT_W    = 4;
    localparam int SIZE_W        = 5;
    localparam int RESET_SIZE    = 11;

    // remainder unit: key padded to a whole number of steps, msb first
    localparam int BITS_PER_STEP = 8;
    localparam int HASH_STEPS    = 4;
    localparam int SHIFT_W       = BITS_PER_STEP * HASH_STEPS;
    localparam int CNT_W         = 2;

    // hash two: floor(s * t / 10) through a reciprocal, exact for s * t below 320
    localparam int DEC_BASE      = 10;
    localparam int DEC_W         = 4;
    localparam int RECIP         = 205;
    localparam int RECIP_SHIFT   = 11;
    localparam int PROD_W        = SIZE_W + DEC_W;
    localparam int SCALED_W      = 16;

    typedef enum logic [KIND_W-1:0] {
        K_LOOKUP = 2'd0,
        K_INSERT = 2'd1,
        K_DELETE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_DELETED = 2'd1,
        ST_USED    = 2'd2
    } t_status;

    typedef struct packed {
        t_status          status;
        logic [KEY_W-1:0] key;
    } t_entry;

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_HASH     = 7'b0000100,
        S_READ     = 7'b0001000,
        S_EXEC     = 7'b0010000,
        S_HASH_OLD = 7'b0100000,
        S_MOVE     = 7'b1000000
    } t_state;

endpackage

[design/two_table_cuckoo_hash_core.sv]
// the result strobe follows the hash steps, the table read and the execute state; an
// insert that finds another key in table one also rehashes that key and runs the move state
// a new item is taken only in idle, so not before the last result shows; the remainder unit
// (8 key bits a cycle) and the read-then-write of the tables set the pace; results show on
// o_done for one cycle and the receiver cannot stall them; reset: table_size goes to 11,
// then both tables are cleared one entry a cycle, busy high until all MAX_SLOTS are clear
module two_table_cuckoo_hash_core #(
    parameter int MAX_SLOTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ttch_pkg::KIND_W-1:0]      i_kind,
    input  logic [ttch_pkg::KEY_W-1:0]       i_key,
    input  logic                             i_cfg_we,
    input  logic [ttch_pkg::SIZE_W-1:0]      i_cfg_data,
    output logic                             o_done,
    output logic                             o_found,
    output logic                             o_which_table,
    output logic [ttch_pkg::SLOT_OUT_W-1:0]  o_slot
);
    import ttch_pkg::*;

    localparam int AW = $clog2(MAX_SLOTS);

    t_entry mem1 [MAX_SLOTS];
    t_entry mem2 [MAX_SLOTS];

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [SHIFT_W-1:0]    r_shift, n_shift;
    logic [SIZE_W-1:0]     r_rem_s, n_rem_s;
    logic [DEC_W-1:0]      r_rem_t, n_rem_t;
    logic [SIZE_W-1:0]     r_p1, n_p1;
    logic [SIZE_W-1:0]     r_p2, n_p2;
    logic [KIND_W-1:0]     r_kind, n_kind;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [KEY_W-1:0]      r_old, n_old;
    logic [AW-1:0]         r_clr_idx, n_clr_idx;
    logic [SIZE_W-1:0]     r_table_size;
    logic                  r_done, n_done;
    logic                  r_found, n_found;
    logic                  r_which, n_which;
    logic [SLOT_OUT_W-1:0] r_slot, n_slot;
    t_entry                r_rd1, r_rd2;

    logic [SIZE_W-1:0]     s_use;
    logic [SIZE_W-1:0]     acc_s;
    logic [DEC_W-1:0]      acc_t;
    logic [SIZE_W:0]       wide_s;
    logic [DEC_W:0]        wide_t;
    logic [SIZE_W-1:0]     h1_now, h2_now;
    logic                  holds1, holds2;

    logic                  w1_en, w2_en;
    logic [AW-1:0]         w1_addr, w2_addr, rd1_addr, rd2_addr;
    t_entry                w1_data, w2_data;

    function automatic logic [SIZE_W-1:0] hash_two(input logic [SIZE_W-1:0] s,
                                                   input logic [DEC_W-1:0] rem10);
        logic [DEC_W-1:0]    t;
        logic [PROD_W-1:0]   prod;
        logic [SCALED_W-1:0] scaled;
        // (9*key) mod 10 is (10 - key mod 10) mod 10
        t      = (rem10 == '0) ? '0 : DEC_W'(DEC_BASE - int'(rem10));
        prod   = PROD_W'(s) * PROD_W'(t);
        scaled = SCALED_W'(prod) * SCALED_W'(RECIP);
        return scaled[RECIP_SHIFT +: SIZE_W];
    endfunction

    always_comb begin
        if (r_table_size == '0) begin
            s_use = SIZE_W'(1);
        end else if (int'(r_table_size) > MAX_SLOTS) begin
            s_use = SIZE_W'(MAX_SLOTS);
        end else begin
            s_use = r_table_size;
        end
    end

    // remainders by s_use and by ten, one key bit per inner step
    always_comb begin
        acc_s  = r_rem_s;
        acc_t  = r_rem_t;
        wide_s = '0;
        wide_t = '0;
        for (int i = 0; i < BITS_PER_STEP; i++) begin
            wide_s = {acc_s, r_shift[SHIFT_W-1-i]};
            if (wide_s >= {1'b0, s_use}) begin
                wide_s = wide_s - {1'b0, s_use};
            end
            acc_s  = wide_s[SIZE_W-1:0];
            wide_t = {acc_t, r_shift[SHIFT_W-1-i]};
            if (wide_t >= (DEC_W+1)'(DEC_BASE)) begin
                wide_t = wide_t - (DEC_W+1)'(DEC_BASE);
            end
            acc_t  = wide_t[DEC_W-1:0];
        end
    end

    assign h1_now = r_rem_s;
    assign h2_now = hash_two(s_use, r_rem_t);
    assign holds1 = (r_rd1.status == ST_USED) && (r_rd1.key == r_key);
    assign holds2 = (r_rd2.status == ST_USED) && (r_rd2.key == r_key);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_shift   = r_shift;
        n_rem_s   = r_rem_s;
        n_rem_t   = r_rem_t;
        n_p1      = r_p1;
        n_p2      = r_p2;
        n_kind    = r_kind;
        n_key     = r_key;
        n_old     = r_old;
        n_clr_idx = r_clr_idx;
        n_done    = 1'b0;
        n_found   = 1'b0;
        n_which   = 1'b0;
        n_slot    = '0;
        w1_en     = 1'b0;
        w2_en     = 1'b0;
        w1_addr   = AW'(r_p1);
        w2_addr   = AW'(r_p2);
        w1_data   = '{status: ST_FREE, key: '0};
        w2_data   = '{status: ST_FREE, key: '0};
        rd1_addr  = AW'(r_p1);
        rd2_addr  = AW'(r_p2);

        unique case (r_state)
            S_CLEAR: begin
                w1_en     = 1'b1;
                w2_en     = 1'b1;
                w1_addr   = r_clr_idx;
                w2_addr   = r_clr_idx;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == AW'(MAX_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_kind  = i_kind;
                    n_key   = i_key;
                    n_shift = SHIFT_W'(i_key);
                    n_rem_s = '0;
                    n_rem_t = '0;
                    n_cnt   = '0;
                    n_state = S_HASH;
                end
            end
            S_HASH, S_HASH_OLD: begin
                n_shift = r_shift << BITS_PER_STEP;
                n_rem_s = acc_s;
                n_rem_t = acc_t;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(HASH_STEPS - 1)) begin
                    n_state = (r_state == S_HASH) ? S_READ : S_MOVE;
                end
            end
            S_READ: begin
                n_p1     = h1_now;
                n_p2     = h2_now;
                rd1_addr = AW'(h1_now);
                rd2_addr = AW'(h2_now);
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                case (r_kind)
                    K_LOOKUP: begin
                        if (holds1) begin
                            n_found = 1'b1;
                            n_slot  = SLOT_OUT_W'(r_p1);
                        end else if (holds2) begin
                            n_found = 1'b1;
                            n_which = 1'b1;
                            n_slot  = SLOT_OUT_W'(r_p2);
                        end
                    end
                    K_INSERT: begin
                        if (r_rd1.status != ST_USED) begin
                            w1_en   = 1'b1;
                            w1_data = '{status: ST_USED, key: r_key};
                        end else if (r_rd1.key != r_key) begin
                            // occupant must be rehashed before it can move
                            n_done  = 1'b0;
                            n_old   = r_rd1.key;
                            n_shift = SHIFT_W'(r_rd1.key);
                            n_rem_s = '0;
                            n_rem_t = '0;
                            n_cnt   = '0;
                            n_state = S_HASH_OLD;
                        end
                    end
                    K_DELETE: begin
                        if (holds1) begin
                            w1_en   = 1'b1;
                            w1_data = '{status: ST_DELETED, key: r_rd1.key};
                        end else if (r_rd1.status != ST_FREE && holds2) begin
                            w2_en   = 1'b1;
                            w2_data = '{status: ST_DELETED, key: r_rd2.key};
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_MOVE: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                // stale occupant that no longer hashes here stays put
                if (h1_now == r_p1) begin
                    w1_en   = 1'b1;
                    w1_data = '{status: ST_USED, key: r_key};
                    w2_en   = 1'b1;
                    w2_addr = AW'(h2_now);
                    w2_data = '{status: ST_USED, key: r_old};
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w1_en) begin
            mem1[w1_addr] <= w1_data;
        end
        r_rd1 <= mem1[rd1_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w2_en) begin
            mem2[w2_addr] <= w2_data;
        end
        r_rd2 <= mem2[rd2_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_cnt        <= '0;
            r_done       <= 1'b0;
            r_table_size <= SIZE_W'(RESET_SIZE);
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_cnt     <= n_cnt;
            r_done    <= n_done;
            if (i_cfg_we) begin
                r_table_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_rem_s <= n_rem_s;
        r_rem_t <= n_rem_t;
        r_p1    <= n_p1;
        r_p2    <= n_p2;
        r_kind  <= n_kind;
        r_key   <= n_key;
        r_old   <= n_old;
        r_found <= n_found;
        r_which <= n_which;
        r_slot  <= n_slot;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_which_table = r_which;
    assign o_slot        = r_slot;

    a_done_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while still busy");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but block not busy");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two result beats in a row");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_found) |-> (!o_which_table && (o_slot == '0)))
        else $error("miss carries nonzero table or slot");

endmodule

[tb/sv/two_table_cuckoo_hash_core_tb.sv]
module two_table_cuckoo_hash_core_tb;
    import ttch_pkg::*;

    localparam int TB_SLOTS = 16;
    localparam int TB_AW = $clog2(TB_SLOTS);
    localparam int POOL_SIZE = 16;
    localparam int POOL_AW = $clog2(POOL_SIZE);
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 15;
    localparam int PHASE_ITEMS = 90;
    localparam int PHASES = 10;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_TOP = {KEY_W{1'b1}};

    typedef struct {
        logic                  found;
        logic                  which_tbl;
        logic [SLOT_OUT_W-1:0] slot;
    } t_lookup_result;

    class hash_scoreboard;
        t_entry              first_tbl[TB_SLOTS];
        t_entry              second_tbl[TB_SLOTS];
        logic [SIZE_W-1:0]   size_reg;
        t_lookup_result      expected_q[$];
        int                  errors;

        function new();
            first_tbl = '{default: '0};
            second_tbl = '{default: '0};
            size_reg = SIZE_W'(RESET_SIZE);
            errors = 0;
        endfunction

        function void report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void note_size(logic [SIZE_W-1:0] v);
            size_reg = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // size register clamped into 1..TB_SLOTS
        function int unsigned span();
            if (size_reg == '0)
                return 1;
            if (32'(size_reg) > TB_SLOTS)
                return TB_SLOTS;
            return 32'(size_reg);
        endfunction

        // floor(s * frac(key * 0.9) * 10 / 10) done in integers
        function int unsigned second_hash(logic [KEY_W-1:0] k, int unsigned s);
            int unsigned tenths;
            tenths = ((32'(k) % 10) * 9) % 10;
            return (s * tenths) / 10;
        endfunction

        function bit holds(t_entry e, logic [KEY_W-1:0] k);
            return e.status == ST_USED && e.key == k;
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] k);
            int unsigned      s;
            logic [TB_AW-1:0] p1;
            logic [TB_AW-1:0] p2;
            logic [TB_AW-1:0] q;
            logic [KEY_W-1:0] old_key;
            t_lookup_result   r;
            s = span();
            p1 = TB_AW'(32'(k) % s);
            p2 = TB_AW'(second_hash(k, s));
            r.found = 1'b0;
            r.which_tbl = 1'b0;
            r.slot = '0;
            case (kind)
                K_LOOKUP: begin
                    if (holds(first_tbl[p1], k)) begin
                        r.found = 1'b1;
                        r.slot = SLOT_OUT_W'(p1);
                    end else if (holds(second_tbl[p2], k)) begin
                        r.found = 1'b1;
                        r.which_tbl = 1'b1;
                        r.slot = SLOT_OUT_W'(p2);
                    end
                end
                K_INSERT: begin
                    if (first_tbl[p1].status != ST_USED) begin
                        first_tbl[p1].status = ST_USED;
                        first_tbl[p1].key = k;
                    end else if ((32'(first_tbl[p1].key) % s) == 32'(p1)
                                 && first_tbl[p1].key != k) begin
                        // occupant is kicked into table two, overwriting it
                        old_key = first_tbl[p1].key;
                        q = TB_AW'(second_hash(old_key, s));
                        first_tbl[p1].key = k;
                        second_tbl[q].status = ST_USED;
                        second_tbl[q].key = old_key;
                    end
                end
                K_DELETE: begin
                    if (holds(first_tbl[p1], k))
                        first_tbl[p1].status = ST_DELETED;
                    else if (first_tbl[p1].status != ST_FREE && holds(second_tbl[p2], k))
                        second_tbl[p2].status = ST_DELETED;
                end
                default: begin
                end
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_result(logic f, logic w, logic [SLOT_OUT_W-1:0] sl);
            t_lookup_result e;
            if (expected_q.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
                return;
            end
            e = expected_q.pop_front();
            if (f !== e.found)
                report_mismatch($sformatf("found got %b want %b", f, e.found));
            if (w !== e.which_tbl)
                report_mismatch($sformatf("which_table got %b want %b", w, e.which_tbl));
            if (sl !== e.slot)
                report_mismatch($sformatf("slot got %0d want %0d", sl, e.slot));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [KIND_W-1:0]     i_kind = '0;
    logic [KEY_W-1:0]      i_key = '0;
    logic                  i_cfg_we = 1'b0;
    logic [SIZE_W-1:0]     i_cfg_data = '0;
    logic                  o_done;
    logic                  o_found;
    logic                  o_which_table;
    logic [SLOT_OUT_W-1:0] o_slot;

    hash_scoreboard        sb = new();
    int                    stall_cycles = 0;
    logic [KEY_W-1:0]      key_pool[POOL_SIZE];

    two_table_cuckoo_hash_core #(
        .MAX_SLOTS(TB_SLOTS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_kind(i_kind),
        .i_key(i_key),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .o_done(o_done),
        .o_found(o_found),
        .o_which_table(o_which_table),
        .o_slot(o_slot)
    );

    always #5 i_clk = ~i_clk;

    // results are checked before the new request beat is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done === 1'b1)
                sb.check_result(o_found, o_which_table, o_slot);
            if (i_cfg_we)
                sb.note_size(i_cfg_data);
            if (start && busy === 1'b0)
                sb.note_request(i_kind, i_key);
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1 || i_cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] k, int gap);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_kind <= kind;
        i_key <= k;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic refresh_pool();
        // keep a few old keys so entries survive a size change
        for (int i = 4; i < POOL_SIZE; i++) begin
            case ($urandom_range(0, 3))
                0: key_pool[POOL_AW'(i)] = KEY_W'($urandom_range(0, 40));
                1: key_pool[POOL_AW'(i)] = KEY_W'($urandom());
                2: key_pool[POOL_AW'(i)] = KEY_W'(KEY_TOP - $urandom_range(0, 40));
                default: key_pool[POOL_AW'(i)] =
                    KEY_W'($urandom_range(0, 15) * $urandom_range(1, 17));
            endcase
        end
    endtask

    initial begin
        int                 pick;
        int                 gap;
        bit                 no_idle;
        logic [KIND_W-1:0]  kind;
        logic [KEY_W-1:0]   k;
        logic [SIZE_W-1:0]  sz;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // tables are being cleared while busy is high
        while (busy !== 1'b0) @(posedge i_clk);

        // reset size of 11: collisions, moves, deletes in both tables
        send_request(K_LOOKUP, 0, 0);
        send_request(K_INSERT, 0, $urandom_range(0, 3));
        send_request(K_LOOKUP, 0, 0);
        send_request(K_INSERT, 11, $urandom_range(0, 3));
        send_request(K_LOOKUP, 0, 0);
        send_request(K_INSERT, 11, 1);
        send_request(K_LOOKUP, 11, 0);
        send_request(K_DELETE, 0, 2);
        send_request(K_LOOKUP, 0, 0);
        send_request(K_DELETE, 11, 0);
        send_request(K_LOOKUP, 11, 3);
        send_request(K_INSERT, 1, 0);
        send_request(K_INSERT, 12, 0);
        send_request(K_DELETE, 12, 0);
        send_request(K_DELETE, 1, 0);
        send_request(K_INSERT, KEY_TOP, 5);
        send_request(K_LOOKUP, KEY_TOP, 0);
        send_request(KIND_UNUSED, KEY_TOP, 0);
        wait_idle();

        // size zero acts as one
        write_size(0);
        send_request(K_INSERT, 7, 0);
        send_request(K_INSERT, 9, 0);
        send_request(K_LOOKUP, 7, 0);
        wait_idle();

        // oversize acts as sixteen; occupant of slot zero is now stale
        write_size(31);
        send_request(K_INSERT, 16, 0);
        send_request(K_LOOKUP, 16, 0);
        send_request(K_LOOKUP, 7, 0);
        send_request(K_DELETE, 7, 0);
        wait_idle();

        for (int i = 0; i < 4; i++)
            key_pool[POOL_AW'(i)] = KEY_W'($urandom_range(0, 20));
        no_idle = 1'b0;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: sz = SIZE_W'(1);
                1: sz = SIZE_W'(16);
                2: sz = SIZE_W'(0);
                3: sz = SIZE_W'(31);
                4: sz = SIZE_W'(RESET_SIZE);
                5: sz = SIZE_W'(2);
                default: sz = SIZE_W'($urandom_range(0, 31));
            endcase
            write_size(sz);
            refresh_pool();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 29) == 0)
                    no_idle = ~no_idle;
                gap = no_idle ? 0 : $urandom_range(0, 15);
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    kind = K_LOOKUP;
                else if (pick < 72)
                    kind = K_INSERT;
                else if (pick < 94)
                    kind = K_DELETE;
                else
                    kind = KIND_UNUSED;
                if ($urandom_range(0, 99) < 85)
                    k = key_pool[POOL_AW'($urandom_range(0, POOL_SIZE - 1))];
                else
                    k = KEY_W'($urandom());
                send_request(kind, k, gap);
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

[files.f]
design/ttch_pkg.sv
design/two_table_cuckoo_hash_core.sv
tb/sv/two_table_cuckoo_hash_core_tb.sv
